/* src/assert_macros.svh */
// Assertion macros shared by the hash table modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check a property on every clock edge outside reset.
`define QPH_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check that an antecedent implies a consequent in the same cycle.
`define QPH_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`else
`define QPH_ASSERT(lbl, prop, msg)
`define QPH_ASSERT_IMP(lbl, ante, cons, msg)
`endif
`endif

/* src/qph_pkg.sv */
// Shared types, codes and size-table functions of the quadratic probe hash table.
package qph_pkg;

    localparam int unsigned DEF_INITIAL_SIZE = 11;
    localparam int unsigned DEF_CAPACITY     = 1597;
    localparam int unsigned DEF_KEY_WIDTH    = 32;
    localparam int unsigned DEF_RECORD_WIDTH = 48;
    localparam int unsigned LEAVE_WIDTH      = 32;
    localparam int unsigned ROM_MAX          = 16;
    localparam int unsigned SI_W             = 4;

    // Request modes
    localparam logic [1:0] MODE_INSERT = 2'd0;
    localparam logic [1:0] MODE_SEARCH = 2'd1;
    localparam logic [1:0] MODE_RETIRE = 2'd2;

    // Slot states held in the table
    localparam logic [1:0] SLOT_EMPTY   = 2'd0;
    localparam logic [1:0] SLOT_ACTIVE  = 2'd1;
    localparam logic [1:0] SLOT_RETIRED = 2'd2;

    typedef enum logic [2:0] {
        RES_INSERTED        = 3'd0,
        RES_DUPLICATE       = 3'd1,
        RES_FOUND           = 3'd2,
        RES_FOUND_RETIRED   = 3'd3,
        RES_NOT_FOUND       = 3'd4,
        RES_RETIRED_NOW     = 3'd5,
        RES_ALREADY_RETIRED = 3'd6,
        RES_FULL            = 3'd7
    } result_t;

    typedef enum logic [1:0] {
        FIN_HIT,
        FIN_MISS,
        FIN_FULL
    } fin_kind_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_CHECK,
        S_RCLR,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_RDIV,
        S_RPRD,
        S_RPCHK,
        S_RDONE,
        S_DIV,
        S_PRD,
        S_PCHK,
        S_FIN
    } state_t;

    typedef struct packed {
        logic      latch_in;
        logic      clr_all;
        logic      clr_start;
        logic      clr_step;
        logic      scan_start;
        logic      scan_rd;
        logic      scan_next;
        logic      rh;
        logic      div_start;
        logic      div_step;
        logic      probe_start;
        logic      probe_rd;
        logic      probe_next;
        logic      move_wr;
        logic      rehash_done;
        logic      finish;
        fin_kind_t kind;
    } cmd_t;

    typedef struct packed {
        logic need_rehash;
        logic no_bigger;
        logic clr_last;
        logic scan_last;
        logic scan_occ;
        logic div_done;
        logic probe_hit;
        logic probe_last;
        logic is_insert;
    } sts_t;

    // Remainder by shift and subtract, used only while elaborating the size table
    function automatic int unsigned mod_u(input int unsigned a, input int unsigned b);
        logic [32:0] r;
        logic [31:0] av;
        av = a;
        r = '0;
        for (int k = 31; k >= 0; k--) begin
            r = {r[31:0], av[k]};
            if (r >= 33'(b)) r = r - 33'(b);
        end
        return int'(r[31:0]);
    endfunction

    function automatic bit is_prime(input int unsigned n);
        int unsigned d;
        if (n < 2) return 1'b0;
        for (d = 2; d * d <= n; d++) begin
            if (mod_u(n, d) == 0) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic int unsigned next_prime(input int unsigned s);
        int unsigned n;
        n = 2 * s + 1;
        while (!is_prime(n)) n++;
        return n;
    endfunction

    function automatic int unsigned first_size(input int unsigned init, input int unsigned cap);
        int unsigned s;
        s = (init > cap) ? cap : init;
        if (s < 1) s = 1;
        return s;
    endfunction

    // Table size at a ROM position; positions past the end repeat the last size
    function automatic int unsigned rom_size(input int unsigned init, input int unsigned cap,
                                             input int unsigned idx);
        int unsigned s;
        int unsigned n;
        s = first_size(init, cap);
        for (int unsigned k = 0; k < idx; k++) begin
            n = next_prime(s);
            if (n > cap) return s;
            s = n;
        end
        return s;
    endfunction

    function automatic int unsigned rom_count(input int unsigned init, input int unsigned cap);
        int unsigned s;
        int unsigned n;
        int unsigned c;
        s = first_size(init, cap);
        c = 1;
        while (c < ROM_MAX) begin
            n = next_prime(s);
            if (n > cap) break;
            c++;
            s = n;
        end
        return c;
    endfunction

endpackage

/* src/quadratic_probe_hash_table.sv */
// A search, retire or plain insert divides the key by the table size bit by bit, then probes
// slots and raises out_valid with the result; no new request is taken before the current one finishes.
// An insert that grows the table first clears new_size slots, then scans every old slot and
// divides and probes again for each stored entry to move it into the new bank.
// After reset a clearing pass writes all 2*CAPACITY slots of both banks before in_ready rises.
// rst_n is asynchronous and active low; it starts the pass that empties both banks, and size returns to the first.
module quadratic_probe_hash_table #(
    parameter int unsigned INITIAL_SIZE = qph_pkg::DEF_INITIAL_SIZE,
    parameter int unsigned CAPACITY     = qph_pkg::DEF_CAPACITY,
    parameter int unsigned KEY_WIDTH    = qph_pkg::DEF_KEY_WIDTH,
    parameter int unsigned RECORD_WIDTH = qph_pkg::DEF_RECORD_WIDTH
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [1:0]                           mode,
    input  logic [KEY_WIDTH-1:0]                 key,
    input  logic [RECORD_WIDTH-1:0]              record_data,
    input  logic [qph_pkg::LEAVE_WIDTH-1:0]      leave_data,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [2:0]                           status,
    output logic [$clog2(CAPACITY+1)-1:0]        slot,
    output logic [RECORD_WIDTH-1:0]              found_record,
    output logic [qph_pkg::LEAVE_WIDTH-1:0]      found_leave,
    output logic [$clog2(CAPACITY/2+1)-1:0]      entry_count,
    output logic [$clog2(CAPACITY+1)-1:0]        current_size
);
    import qph_pkg::*;

    cmd_t cmd;
    sts_t sts;

    // Sequence the request
    qph_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // Store, divide and probe
    qph_datapath #(
        .INITIAL_SIZE (INITIAL_SIZE),
        .CAPACITY     (CAPACITY),
        .KEY_WIDTH    (KEY_WIDTH),
        .RECORD_WIDTH (RECORD_WIDTH)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .mode         (mode),
        .key          (key),
        .record_data  (record_data),
        .leave_data   (leave_data),
        .status       (status),
        .slot         (slot),
        .found_record (found_record),
        .found_leave  (found_leave),
        .entry_count  (entry_count),
        .current_size (current_size)
    );

endmodule

/* src/qph_datapath.sv */
// Datapath: slot memory, key divider, probe walker, counters and result registers.
`include "assert_macros.svh"
module qph_datapath #(
    parameter int unsigned INITIAL_SIZE = qph_pkg::DEF_INITIAL_SIZE,
    parameter int unsigned CAPACITY     = qph_pkg::DEF_CAPACITY,
    parameter int unsigned KEY_WIDTH    = qph_pkg::DEF_KEY_WIDTH,
    parameter int unsigned RECORD_WIDTH = qph_pkg::DEF_RECORD_WIDTH
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  qph_pkg::cmd_t                        cmd,
    output qph_pkg::sts_t                        sts,
    input  logic [1:0]                           mode,
    input  logic [KEY_WIDTH-1:0]                 key,
    input  logic [RECORD_WIDTH-1:0]              record_data,
    input  logic [qph_pkg::LEAVE_WIDTH-1:0]      leave_data,
    output logic [2:0]                           status,
    output logic [$clog2(CAPACITY+1)-1:0]        slot,
    output logic [RECORD_WIDTH-1:0]              found_record,
    output logic [qph_pkg::LEAVE_WIDTH-1:0]      found_leave,
    output logic [$clog2(CAPACITY/2+1)-1:0]      entry_count,
    output logic [$clog2(CAPACITY+1)-1:0]        current_size
);
    import qph_pkg::*;

    localparam int unsigned SZ_W  = $clog2(CAPACITY + 1);
    localparam int unsigned CNT_W = $clog2(CAPACITY / 2 + 1);
    localparam int unsigned AW    = $clog2(2 * CAPACITY);
    localparam int unsigned DCW   = $clog2(KEY_WIDTH + 1);
    localparam int unsigned NW    = SZ_W + 2;
    localparam int unsigned SIW1  = SI_W + 1;
    localparam int unsigned ROM_CNT = rom_count(INITIAL_SIZE, CAPACITY);
    localparam int unsigned SIZE_ROM [ROM_MAX] = '{
        rom_size(INITIAL_SIZE, CAPACITY, 0),  rom_size(INITIAL_SIZE, CAPACITY, 1),
        rom_size(INITIAL_SIZE, CAPACITY, 2),  rom_size(INITIAL_SIZE, CAPACITY, 3),
        rom_size(INITIAL_SIZE, CAPACITY, 4),  rom_size(INITIAL_SIZE, CAPACITY, 5),
        rom_size(INITIAL_SIZE, CAPACITY, 6),  rom_size(INITIAL_SIZE, CAPACITY, 7),
        rom_size(INITIAL_SIZE, CAPACITY, 8),  rom_size(INITIAL_SIZE, CAPACITY, 9),
        rom_size(INITIAL_SIZE, CAPACITY, 10), rom_size(INITIAL_SIZE, CAPACITY, 11),
        rom_size(INITIAL_SIZE, CAPACITY, 12), rom_size(INITIAL_SIZE, CAPACITY, 13),
        rom_size(INITIAL_SIZE, CAPACITY, 14), rom_size(INITIAL_SIZE, CAPACITY, 15)
    };

    typedef struct packed {
        logic [1:0]              st;
        logic [KEY_WIDTH-1:0]    k;
        logic [RECORD_WIDTH-1:0] rec;
        logic [LEAVE_WIDTH-1:0]  lv;
    } entry_t;

    function automatic logic [AW-1:0] slot_addr(input logic b, input logic [SZ_W-1:0] p);
        return b ? (AW'(p) + AW'(CAPACITY)) : AW'(p);
    endfunction

    entry_t mem [2*CAPACITY];

    // Latched request
    logic [1:0]              mode_reg;
    logic [KEY_WIDTH-1:0]    key_reg;
    logic [RECORD_WIDTH-1:0] rec_reg;
    logic [LEAVE_WIDTH-1:0]  leave_reg;

    // Table state and walkers
    logic             bank_reg;
    logic [SI_W-1:0]  si_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [AW-1:0]    clr_reg;
    logic [SZ_W-1:0]  scan_reg;
    logic [DCW-1:0]   div_cnt_reg;
    logic [SZ_W-1:0]  div_rem_reg;
    logic [KEY_WIDTH-1:0] div_key_reg;
    logic [SZ_W-1:0]  home_reg;
    logic [SZ_W-1:0]  off_reg;
    logic [SZ_W-1:0]  stp_reg;
    logic [SZ_W-1:0]  pidx_reg;
    entry_t           mv_reg;
    entry_t           rdata_reg;

    // Result registers
    result_t          res_reg;
    logic [SZ_W-1:0]  slot_reg;
    logic [RECORD_WIDTH-1:0] frec_reg;
    logic [LEAVE_WIDTH-1:0]  flv_reg;
    logic [CNT_W-1:0] ecnt_reg;
    logic [SZ_W-1:0]  esize_reg;

    logic [SZ_W-1:0]  cur_size;
    logic [SZ_W-1:0]  new_size;
    logic [SZ_W-1:0]  psize;
    logic             pbank;
    logic [KEY_WIDTH-1:0] pkey;
    logic [SZ_W:0]    pos_sum;
    logic [SZ_W-1:0]  pos_w;
    logic [SZ_W:0]    div_r2;
    logic [SZ_W:0]    off_sum;
    logic [SZ_W:0]    stp_sum;

    logic             we;
    logic [AW-1:0]    waddr;
    entry_t           wdata;
    logic             rd_en;
    logic [AW-1:0]    raddr;

    result_t          res;
    logic [SZ_W-1:0]  res_slot;
    logic [RECORD_WIDTH-1:0] res_rec;
    logic [LEAVE_WIDTH-1:0]  res_lv;
    logic             fin_we;
    entry_t           fin_data;
    logic             cnt_inc;

    // Select sizes and the probe target for a lookup or a rehash move
    assign cur_size = SZ_W'(SIZE_ROM[si_reg]);
    assign new_size = SZ_W'(SIZE_ROM[si_reg + SI_W'(1)]);
    assign psize    = cmd.rh ? new_size : cur_size;
    assign pbank    = cmd.rh ? ~bank_reg : bank_reg;
    assign pkey     = cmd.rh ? mv_reg.k : key_reg;

    // Reduce home plus squared offset
    assign pos_sum = {1'b0, home_reg} + {1'b0, off_reg};
    assign pos_w   = (pos_sum >= {1'b0, psize}) ? SZ_W'(pos_sum - {1'b0, psize})
                                                : SZ_W'(pos_sum);

    assign div_r2  = {div_rem_reg, div_key_reg[KEY_WIDTH-1]};
    assign off_sum = {1'b0, off_reg} + {1'b0, stp_reg};
    assign stp_sum = {1'b0, stp_reg} + (SZ_W+1)'(2);

    // Status toward the controller
    always_comb
    begin
        sts.need_rehash = ((NW'(cnt_reg) + NW'(1)) << 1) > NW'(cur_size);
        sts.no_bigger   = (SIW1'(si_reg) + SIW1'(1)) >= SIW1'(ROM_CNT);
        sts.clr_last    = cmd.clr_all ? (clr_reg == AW'(2 * CAPACITY - 1))
                                      : (clr_reg == (AW'(new_size) - AW'(1)));
        sts.scan_last   = (scan_reg == (cur_size - SZ_W'(1)));
        sts.scan_occ    = (rdata_reg.st != SLOT_EMPTY);
        sts.div_done    = (div_cnt_reg == DCW'(KEY_WIDTH));
        sts.probe_hit   = (rdata_reg.st == SLOT_EMPTY) || (rdata_reg.k == pkey);
        sts.probe_last  = (pidx_reg == (psize - SZ_W'(1)));
        sts.is_insert   = (mode_reg == MODE_INSERT);
    end

    // Decide the outcome of a finished request
    always_comb
    begin
        res      = RES_NOT_FOUND;
        res_slot = pos_w;
        res_rec  = '0;
        res_lv   = '0;
        fin_we   = 1'b0;
        fin_data = rdata_reg;
        cnt_inc  = 1'b0;
        case (cmd.kind)
            FIN_FULL:
            begin
                res      = RES_FULL;
                res_slot = '0;
            end
            FIN_MISS:
            begin
                res      = (mode_reg == MODE_INSERT) ? RES_FULL : RES_NOT_FOUND;
                res_slot = home_reg;
            end
            FIN_HIT:
            begin
                if (mode_reg == MODE_INSERT)
                begin
                    if (rdata_reg.st == SLOT_EMPTY)
                    begin
                        fin_we       = 1'b1;
                        fin_data.st  = SLOT_ACTIVE;
                        fin_data.k   = key_reg;
                        fin_data.rec = rec_reg;
                        cnt_inc      = 1'b1;
                        res          = RES_INSERTED;
                    end
                    else
                    begin
                        res     = RES_DUPLICATE;
                        res_rec = rdata_reg.rec;
                        if (rdata_reg.st == SLOT_RETIRED) res_lv = rdata_reg.lv;
                    end
                end
                else if (rdata_reg.st == SLOT_EMPTY)
                begin
                    res = RES_NOT_FOUND;
                end
                else if (rdata_reg.st == SLOT_RETIRED)
                begin
                    res     = (mode_reg == MODE_RETIRE) ? RES_ALREADY_RETIRED
                                                        : RES_FOUND_RETIRED;
                    res_rec = rdata_reg.rec;
                    res_lv  = rdata_reg.lv;
                end
                else if (mode_reg == MODE_RETIRE)
                begin
                    fin_we      = 1'b1;
                    fin_data.st = SLOT_RETIRED;
                    fin_data.lv = leave_reg;
                    res         = RES_RETIRED_NOW;
                    res_rec     = rdata_reg.rec;
                    res_lv      = leave_reg;
                end
                else
                begin
                    res     = RES_FOUND;
                    res_rec = rdata_reg.rec;
                end
            end
            default:
            begin
                res = RES_NOT_FOUND;
            end
        endcase
    end

    // Select the memory write and read
    always_comb
    begin
        we    = 1'b0;
        waddr = slot_addr(bank_reg, pos_w);
        wdata = fin_data;
        if (cmd.clr_step)
        begin
            we    = 1'b1;
            waddr = cmd.clr_all ? clr_reg : slot_addr(~bank_reg, clr_reg[SZ_W-1:0]);
            wdata = '0;
        end
        else if (cmd.move_wr)
        begin
            we    = 1'b1;
            waddr = slot_addr(~bank_reg, pos_w);
            wdata = mv_reg;
        end
        else if (cmd.finish && fin_we)
        begin
            we = 1'b1;
        end
        rd_en = cmd.scan_rd || cmd.probe_rd;
        raddr = cmd.scan_rd ? slot_addr(bank_reg, scan_reg) : slot_addr(pbank, pos_w);
    end

    // Slot memory with registered read
    always_ff @(posedge clk)
    begin
        if (we) mem[waddr] <= wdata;
        if (rd_en) rdata_reg <= mem[raddr];
    end

    // Table state and walker counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bank_reg    <= 1'b0;
            si_reg      <= '0;
            cnt_reg     <= '0;
            clr_reg     <= '0;
            scan_reg    <= '0;
            div_cnt_reg <= '0;
            pidx_reg    <= '0;
        end
        else
        begin
            if (cmd.clr_start) clr_reg <= '0;
            else if (cmd.clr_step) clr_reg <= clr_reg + AW'(1);
            if (cmd.scan_start) scan_reg <= '0;
            else if (cmd.scan_next) scan_reg <= scan_reg + SZ_W'(1);
            if (cmd.div_start) div_cnt_reg <= '0;
            else if (cmd.div_step) div_cnt_reg <= div_cnt_reg + DCW'(1);
            if (cmd.probe_start) pidx_reg <= '0;
            else if (cmd.probe_next) pidx_reg <= pidx_reg + SZ_W'(1);
            if (cmd.rehash_done)
            begin
                bank_reg <= ~bank_reg;
                si_reg   <= si_reg + SI_W'(1);
            end
            if (cmd.finish && cnt_inc) cnt_reg <= cnt_reg + CNT_W'(1);
        end
    end

    // Request, divider, probe and result payload
    always_ff @(posedge clk)
    begin
        if (cmd.latch_in)
        begin
            mode_reg  <= mode;
            key_reg   <= key;
            rec_reg   <= record_data;
            leave_reg <= leave_data;
        end
        if (cmd.div_start)
        begin
            div_rem_reg <= '0;
            div_key_reg <= cmd.rh ? rdata_reg.k : key_reg;
            if (cmd.rh) mv_reg <= rdata_reg;
        end
        else if (cmd.div_step)
        begin
            div_rem_reg <= (div_r2 >= {1'b0, psize}) ? SZ_W'(div_r2 - {1'b0, psize})
                                                     : SZ_W'(div_r2);
            div_key_reg <= div_key_reg << 1;
        end
        if (cmd.probe_start)
        begin
            home_reg <= div_rem_reg;
            off_reg  <= '0;
            stp_reg  <= SZ_W'(1);
        end
        else if (cmd.probe_next)
        begin
            off_reg <= (off_sum >= {1'b0, psize}) ? SZ_W'(off_sum - {1'b0, psize})
                                                  : SZ_W'(off_sum);
            stp_reg <= (stp_sum >= {1'b0, psize}) ? SZ_W'(stp_sum - {1'b0, psize})
                                                  : SZ_W'(stp_sum);
        end
        if (cmd.finish)
        begin
            res_reg   <= res;
            slot_reg  <= res_slot;
            frec_reg  <= res_rec;
            flv_reg   <= res_lv;
            ecnt_reg  <= cnt_reg + CNT_W'(cnt_inc);
            esize_reg <= cur_size;
        end
    end

    assign status       = res_reg;
    assign slot         = slot_reg;
    assign found_record = frec_reg;
    assign found_leave  = flv_reg;
    assign entry_count  = ecnt_reg;
    assign current_size = esize_reg;

    `QPH_ASSERT_IMP(a_probe_in_range, cmd.probe_rd, pos_w < psize, "probe slot outside table")
    `QPH_ASSERT_IMP(a_rem_in_range, cmd.div_step, div_rem_reg < psize, "remainder not reduced")
    `QPH_ASSERT(a_load_limit, (NW'(cnt_reg) << 1) <= NW'(cur_size), "load limit exceeded")

endmodule

/* src/qph_ctrl.sv */
// Controller: sequences clearing, rehash, divide, probe and result handoff.
`include "assert_macros.svh"
module qph_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    output logic          out_valid,
    input  logic          out_ready,
    input  qph_pkg::sts_t sts,
    output qph_pkg::cmd_t cmd
);
    import qph_pkg::*;

    state_t    state_reg, state_next;
    fin_kind_t kind_reg, kind_next;
    logic      out_valid_reg, out_valid_next;
    logic      out_free;

    assign out_free = !out_valid_reg || out_ready;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        kind_next  = kind_reg;
        case (state_reg)
            S_CLEAR:    if (sts.clr_last) state_next = S_IDLE;
            S_IDLE:     if (in_valid) state_next = S_CHECK;
            S_CHECK:
            begin
                if (sts.is_insert && sts.need_rehash)
                begin
                    if (sts.no_bigger)
                    begin
                        kind_next  = FIN_FULL;
                        state_next = S_FIN;
                    end
                    else
                    begin
                        state_next = S_RCLR;
                    end
                end
                else
                begin
                    state_next = S_DIV;
                end
            end
            S_RCLR:     if (sts.clr_last) state_next = S_SCAN_RD;
            S_SCAN_RD:  state_next = S_SCAN_CHK;
            S_SCAN_CHK:
            begin
                if (sts.scan_occ) state_next = S_RDIV;
                else if (sts.scan_last) state_next = S_RDONE;
                else state_next = S_SCAN_RD;
            end
            S_RDIV:     if (sts.div_done) state_next = S_RPRD;
            S_RPRD:     state_next = S_RPCHK;
            S_RPCHK:
            begin
                if (sts.probe_hit || sts.probe_last)
                    state_next = sts.scan_last ? S_RDONE : S_SCAN_RD;
                else
                    state_next = S_RPRD;
            end
            S_RDONE:    state_next = S_CHECK;
            S_DIV:      if (sts.div_done) state_next = S_PRD;
            S_PRD:      state_next = S_PCHK;
            S_PCHK:
            begin
                if (sts.probe_hit)
                begin
                    kind_next  = FIN_HIT;
                    state_next = S_FIN;
                end
                else if (sts.probe_last)
                begin
                    kind_next  = FIN_MISS;
                    state_next = S_FIN;
                end
                else
                begin
                    state_next = S_PRD;
                end
            end
            S_FIN:      if (out_free) state_next = S_IDLE;
            default:    state_next = S_IDLE;
        endcase
    end

    // Commands
    always_comb
    begin
        cmd      = '0;
        cmd.kind = kind_reg;
        in_ready = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_all  = 1'b1;
                cmd.clr_step = 1'b1;
            end
            S_IDLE:
            begin
                in_ready     = 1'b1;
                cmd.latch_in = in_valid;
            end
            S_CHECK:
            begin
                if (sts.is_insert && sts.need_rehash)
                begin
                    cmd.clr_start  = !sts.no_bigger;
                    cmd.scan_start = !sts.no_bigger;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                end
            end
            S_RCLR:
            begin
                cmd.rh       = 1'b1;
                cmd.clr_step = 1'b1;
            end
            S_SCAN_RD:
            begin
                cmd.rh      = 1'b1;
                cmd.scan_rd = 1'b1;
            end
            S_SCAN_CHK:
            begin
                cmd.rh        = 1'b1;
                cmd.div_start = sts.scan_occ;
                cmd.scan_next = !sts.scan_occ && !sts.scan_last;
            end
            S_RDIV:
            begin
                cmd.rh          = 1'b1;
                cmd.div_step    = !sts.div_done;
                cmd.probe_start = sts.div_done;
            end
            S_RPRD:
            begin
                cmd.rh       = 1'b1;
                cmd.probe_rd = 1'b1;
            end
            S_RPCHK:
            begin
                cmd.rh         = 1'b1;
                cmd.move_wr    = sts.probe_hit;
                cmd.scan_next  = (sts.probe_hit || sts.probe_last) && !sts.scan_last;
                cmd.probe_next = !sts.probe_hit && !sts.probe_last;
            end
            S_RDONE:    cmd.rehash_done = 1'b1;
            S_DIV:
            begin
                cmd.div_step    = !sts.div_done;
                cmd.probe_start = sts.div_done;
            end
            S_PRD:      cmd.probe_rd = 1'b1;
            S_PCHK:     cmd.probe_next = !sts.probe_hit && !sts.probe_last;
            S_FIN:      cmd.finish = out_free;
            default:    cmd = '0;
        endcase
    end

    // Hold the result until the transaction completes
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.finish) out_valid_next = 1'b1;
        else if (out_ready) out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            kind_reg      <= FIN_HIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            kind_reg      <= kind_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    `QPH_ASSERT(a_one_at_a_time, in_valid && in_ready |=> !in_ready, "second request taken")
    `QPH_ASSERT_IMP(a_rehash_end, state_reg == S_RDONE, $past(sts.scan_last), "early rehash end")
    `QPH_ASSERT_IMP(a_full_insert, state_reg == S_FIN && kind_reg == FIN_FULL, sts.is_insert,
        "full on a lookup")

endmodule
